[hdl/sstt_pkg.sv]
`default_nettype none

package sstt_pkg;

   // field widths
   localparam int SAMPLE_BITS   = 12;
   localparam int CAL_BITS      = 12;
   localparam int SPAN_BITS     = 11;
   localparam int TRIM_BITS     = 11;
   localparam int CH_BITS       = 3;
   localparam int BYTE_BITS     = 8;
   localparam int VALUE_BITS    = 16;
   localparam int SCREEN_BITS   = 2;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CAL_REG_BITS  = 2 * CAL_BITS + 1;
   localparam int SPAN_REG_BITS = 2 * SPAN_BITS;
   localparam int CSR_DATA_BITS = CAL_REG_BITS;
   localparam int NUM_CAL       = 6;
   localparam int NUM_TRIM      = 4;
   localparam int TRIM_IDX_BITS = $clog2(NUM_TRIM);
   localparam int WINDOW_DEPTH  = 3;
   localparam int QUEUE_DEPTH   = 2;

   // datapath widths
   localparam int ADC_FULL   = (1 << SAMPLE_BITS) - 1;
   localparam int ARG_BITS   = (SAMPLE_BITS > CAL_BITS) ? SAMPLE_BITS : CAL_BITS;
   localparam int DIFF_BITS  = ARG_BITS + 1;
   localparam int NUM_BITS   = DIFF_BITS + SPAN_BITS;
   localparam int PROD_BITS  = NUM_BITS + 1;
   localparam int DIV_ITERS  = (NUM_BITS + 1) / 2;
   localparam int QUO_BITS   = 2 * DIV_ITERS;
   localparam int ITER_BITS  = $clog2(DIV_ITERS);
   localparam int RES_BITS   = QUO_BITS + 3;

   // reset values
   localparam logic [CAL_REG_BITS-1:0]  CAL_RESET_REV = 25'h1FF_F000;
   localparam logic [CAL_REG_BITS-1:0]  CAL_RESET_FWD = 25'h0FF_F000;
   localparam logic [SPAN_REG_BITS-1:0] SPAN_RESET    = 22'd4097000;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_CAL_CH0     = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CAL_CH1     = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CAL_CH2     = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CAL_CH3     = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CAL_CH4     = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CAL_CH5     = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OUTPUT_SPAN = 3'd6;

   // channels
   localparam logic [CH_BITS-1:0] CH_POT0     = 3'd0;
   localparam logic [CH_BITS-1:0] CH_POT1     = 3'd1;
   localparam logic [CH_BITS-1:0] CH_THROTTLE = 3'd2;
   localparam logic [CH_BITS-1:0] CH_YAW      = 3'd3;
   localparam logic [CH_BITS-1:0] CH_ROLL     = 3'd4;
   localparam logic [CH_BITS-1:0] CH_PITCH    = 3'd5;
   localparam logic [CH_BITS-1:0] CH_BATTERY  = 3'd6;
   localparam logic [CH_BITS-1:0] CH_UNUSED   = 3'd7;

   // screens
   localparam logic [SCREEN_BITS-1:0] SCREEN_HOME   = 2'd0;
   localparam logic [SCREEN_BITS-1:0] SCREEN_TRIM   = 2'd1;
   localparam logic [SCREEN_BITS-1:0] SCREEN_BRIGHT = 2'd2;

   // opcodes
   localparam logic OP_EVENT  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // scaling constants
   localparam int TRIM_LIMIT  = 1000;
   localparam int CLAMP_LO    = 1000;
   localparam int CLAMP_HI    = 2000;
   localparam int BATT_SCALE  = 1000;
   localparam int BATT_OFFSET = 1000;

   typedef struct packed {
      logic                   opcode;
      logic [BYTE_BITS-1:0]   event_byte;
      logic [CH_BITS-1:0]     channel;
      logic [SAMPLE_BITS-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [CH_BITS-1:0]     out_channel;
      logic [VALUE_BITS-1:0]  scaled_value;
      logic                   value_valid;
      logic [SCREEN_BITS-1:0] screen_mode;
   } rsp_type;

   typedef logic [NUM_CAL-1:0][CAL_REG_BITS-1:0] cal_bank_type;

   typedef struct packed {
      cal_bank_type             cal;
      logic [SPAN_REG_BITS-1:0] span;
   } cfg_type;

   // one classified transaction waiting for the back end
   typedef struct packed {
      logic                        valid;
      logic                        divide;
      logic [CH_BITS-1:0]          channel;
      logic [SCREEN_BITS-1:0]      screen;
      logic                        num_neg;
      logic [NUM_BITS-1:0]         num_mag;
      logic                        den_neg;
      logic [ARG_BITS-1:0]         den_mag;
      logic [SPAN_BITS-1:0]        omin;
      logic signed [TRIM_BITS-1:0] trim;
   } job_type;

endpackage

`default_nettype wire

[hdl/stick_scaler_with_touch_trim.sv]
`default_nettype none

// stick scaler with touch-panel trim. each request transaction carries either one
// touch-panel event byte (opcode 0) or one 12-bit stick adc sample (opcode 1), and
// each gives exactly one response transaction, in order. event bytes slide through
// a four-byte window that switches the screen (home, trim, brightness) and, on the
// trim screen, steps one of four trims saturating at +/-1000. samples on channels
// 0-5 are mapped from the calibrated input range onto the output span (division
// truncates toward zero, reversed channels use the swapped span); channels 2-5 add
// their trim and clamp to 1000..2000, channels 0-1 report the low 16 bits, channel
// 6 gives floor(1000*x/4095)+1000 and channel 7 comes back with value_valid low.
// the front end classifies a transaction and forms the product in the cycle it
// is taken, into a two-entry queue; the back end picks it up in its idle state,
// runs the radix-4 restoring divider (2 quotient bits a cycle) in its divide
// state for a sample that needs one (not an event byte, a channel 7 sample or an
// empty input range), and loads the response in its finish state; it takes no
// new transaction until then, so the divider sets the sustained rate.
// configuration writes take effect on the next edge and are only legal while
// no transaction is in flight.

module stick_scaler_with_touch_trim (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request channel
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire sstt_pkg::req_type                     req_data,
   // response channel
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output sstt_pkg::rsp_type                          rsp_data,
   // configuration write port
   input  wire logic                                  csr_write_enable,
   input  wire logic [sstt_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  wire logic [sstt_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import sstt_pkg::*;

   // calibration and output span registers
   cal_bank_type             cal_ff;
   logic [SPAN_REG_BITS-1:0] span_ff;
   cfg_type                  cfg;

   // front end to queue
   logic    front_valid, front_ready;
   job_type front_job;

   // queue to back end
   logic    back_valid, back_ready;
   job_type back_job;

   assign cfg.cal  = cal_ff;
   assign cfg.span = span_ff;

   // register writes; an index past the last register is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff[0] <= CAL_RESET_REV;
         cal_ff[1] <= CAL_RESET_REV;
         cal_ff[2] <= CAL_RESET_FWD;
         cal_ff[3] <= CAL_RESET_REV;
         cal_ff[4] <= CAL_RESET_FWD;
         cal_ff[5] <= CAL_RESET_REV;
         span_ff   <= SPAN_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CAL_CH0:     cal_ff[0] <= csr_wdata[CAL_REG_BITS-1:0];
            CSR_CAL_CH1:     cal_ff[1] <= csr_wdata[CAL_REG_BITS-1:0];
            CSR_CAL_CH2:     cal_ff[2] <= csr_wdata[CAL_REG_BITS-1:0];
            CSR_CAL_CH3:     cal_ff[3] <= csr_wdata[CAL_REG_BITS-1:0];
            CSR_CAL_CH4:     cal_ff[4] <= csr_wdata[CAL_REG_BITS-1:0];
            CSR_CAL_CH5:     cal_ff[5] <= csr_wdata[CAL_REG_BITS-1:0];
            CSR_OUTPUT_SPAN: span_ff   <= csr_wdata[SPAN_REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   // front end: event window, screen and trim state, map setup and multiply
   sstt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg),
      .job_valid (front_valid),
      .job_ready (front_ready),
      .job_data  (front_job)
   );

   // short queue so the front end keeps taking transactions while dividing
   sstt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_job),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_job)
   );

   // back end: serial divide, trim, clamp and the response register
   sstt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (back_valid),
      .job_ready (back_ready),
      .job_data  (back_job),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[hdl/sstt_front.sv]
`default_nettype none

module sstt_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire sstt_pkg::req_type req_data,
   input  wire sstt_pkg::cfg_type cfg,
   output logic                  job_valid,
   input  wire logic             job_ready,
   output sstt_pkg::job_type     job_data
);
   import sstt_pkg::*;

   localparam logic [BYTE_BITS-1:0] EVT_MARK = 8'h65;
   localparam logic signed [TRIM_BITS:0] TRIM_MAX  = (TRIM_BITS+1)'(TRIM_LIMIT);
   localparam logic signed [TRIM_BITS:0] TRIM_MIN  = -TRIM_MAX;
   localparam logic signed [TRIM_BITS:0] STEP_UP   = (TRIM_BITS+1)'(1);
   localparam logic signed [TRIM_BITS:0] STEP_DOWN = -STEP_UP;

   logic [BYTE_BITS-1:0]        window_ff [WINDOW_DEPTH];
   logic [SCREEN_BITS-1:0]      screen_ff, screen_in;
   logic signed [TRIM_BITS-1:0] trim_ff [NUM_TRIM];
   logic signed [TRIM_BITS-1:0] trim_in [NUM_TRIM];
   logic signed [TRIM_BITS:0]   trim_sum [NUM_TRIM];

   logic                     accept;
   logic                     is_event;
   logic                     mark_hit, go_home, go_trim, go_bright;
   logic                     step_en, step_hit, step_up;
   logic [TRIM_IDX_BITS-1:0] step_idx;

   logic [CAL_REG_BITS-1:0]       cal_sel;
   logic [SPAN_BITS-1:0]          o_lo, o_hi, omin_map, omax_map;
   logic signed [DIFF_BITS-1:0]   x_ext, min_ext, max_ext, diff, den;
   logic signed [SPAN_BITS:0]     span_diff;
   logic signed [PROD_BITS-1:0]   prod;
   logic [PROD_BITS-1:0]          prod_mag;
   logic [DIFF_BITS-1:0]          den_abs;
   logic [NUM_BITS-1:0]           batt_num;
   logic signed [TRIM_BITS-1:0]   trim_sel;

   assign accept    = req_valid && job_ready;
   assign req_ready = job_ready;
   assign job_valid = req_valid;
   assign is_event  = (req_data.opcode == OP_EVENT);

   // screen and trim decode over the byte window
   always_comb begin
      mark_hit  = (window_ff[0] == EVT_MARK) && (req_data.event_byte == 8'h00);
      go_home   = mark_hit &&
                  ((window_ff[1] == 8'h01 && window_ff[2] == 8'h06) ||
                   (window_ff[1] == 8'h02 && window_ff[2] == 8'h01));
      go_trim   = mark_hit &&
                  ((window_ff[1] == 8'h00 && window_ff[2] == 8'h02) ||
                   (window_ff[1] == 8'h02 && window_ff[2] == 8'h02));
      go_bright = mark_hit &&
                  ((window_ff[1] == 8'h00 && window_ff[2] == 8'h17) ||
                   (window_ff[1] == 8'h01 && window_ff[2] == 8'h13));
      screen_in = screen_ff;
      if (go_home) begin
         screen_in = SCREEN_HOME;
      end
      if (go_trim) begin
         screen_in = SCREEN_TRIM;
      end
      if (go_bright) begin
         screen_in = SCREEN_BRIGHT;
      end
      step_en = (window_ff[0] == EVT_MARK) && (screen_in == SCREEN_TRIM) &&
                (window_ff[1] == 8'h01);
      step_hit = 1'b1;
      step_up  = 1'b1;
      step_idx = '0;
      case (window_ff[2])
         8'h07: begin step_idx = 2'd0; step_up = 1'b1; end
         8'h08: begin step_idx = 2'd0; step_up = 1'b0; end
         8'h09: begin step_idx = 2'd1; step_up = 1'b1; end
         8'h0A: begin step_idx = 2'd1; step_up = 1'b0; end
         8'h0D: begin step_idx = 2'd2; step_up = 1'b1; end
         8'h0E: begin step_idx = 2'd2; step_up = 1'b0; end
         8'h0B: begin step_idx = 2'd3; step_up = 1'b1; end
         8'h0C: begin step_idx = 2'd3; step_up = 1'b0; end
         default: step_hit = 1'b0;
      endcase
      for (int i = 0; i < NUM_TRIM; i++) begin
         trim_sum[i] = (TRIM_BITS+1)'(trim_ff[i]) + (step_up ? STEP_UP : STEP_DOWN);
         trim_in[i]  = trim_ff[i];
         if (step_en && step_hit && step_idx == TRIM_IDX_BITS'(i) &&
             trim_sum[i] >= TRIM_MIN && trim_sum[i] <= TRIM_MAX) begin
            trim_in[i] = trim_sum[i][TRIM_BITS-1:0];
         end
      end
   end

   // linear map setup: numerator product and signed denominator
   always_comb begin
      case (req_data.channel)
         CH_POT0:     cal_sel = cfg.cal[0];
         CH_POT1:     cal_sel = cfg.cal[1];
         CH_THROTTLE: cal_sel = cfg.cal[2];
         CH_YAW:      cal_sel = cfg.cal[3];
         CH_ROLL:     cal_sel = cfg.cal[4];
         CH_PITCH:    cal_sel = cfg.cal[5];
         default:     cal_sel = cfg.cal[0];
      endcase
      case (req_data.channel)
         CH_THROTTLE: trim_sel = trim_ff[0];
         CH_YAW:      trim_sel = trim_ff[1];
         CH_ROLL:     trim_sel = trim_ff[2];
         CH_PITCH:    trim_sel = trim_ff[3];
         default:     trim_sel = '0;
      endcase
      o_lo     = cfg.span[SPAN_BITS-1:0];
      o_hi     = cfg.span[SPAN_REG_BITS-1:SPAN_BITS];
      omin_map = cal_sel[CAL_REG_BITS-1] ? o_hi : o_lo;
      omax_map = cal_sel[CAL_REG_BITS-1] ? o_lo : o_hi;
      span_diff = $signed({1'b0, omax_map}) - $signed({1'b0, omin_map});
      x_ext    = $signed({1'b0, ARG_BITS'(req_data.sample)});
      min_ext  = $signed({1'b0, ARG_BITS'(cal_sel[CAL_BITS-1:0])});
      max_ext  = $signed({1'b0, ARG_BITS'(cal_sel[2*CAL_BITS-1:CAL_BITS])});
      diff     = x_ext - min_ext;
      den      = max_ext - min_ext;
      prod     = PROD_BITS'(diff) * PROD_BITS'(span_diff);
      prod_mag = prod[PROD_BITS-1] ? -prod : prod;
      den_abs  = den[DIFF_BITS-1] ? -den : den;
      batt_num = NUM_BITS'(req_data.sample) * NUM_BITS'(BATT_SCALE);
   end

   always_comb begin
      job_data.valid   = !is_event && (req_data.channel != CH_UNUSED);
      job_data.channel = is_event ? CH_POT0 : req_data.channel;
      job_data.screen  = is_event ? screen_in : screen_ff;
      job_data.trim    = trim_sel;
      if (req_data.channel == CH_BATTERY) begin
         job_data.num_neg = 1'b0;
         job_data.num_mag = batt_num;
         job_data.den_neg = 1'b0;
         job_data.den_mag = ARG_BITS'(ADC_FULL);
         job_data.omin    = SPAN_BITS'(BATT_OFFSET);
      end else begin
         job_data.num_neg = prod[PROD_BITS-1];
         job_data.num_mag = prod_mag[NUM_BITS-1:0];
         job_data.den_neg = den[DIFF_BITS-1];
         job_data.den_mag = den_abs[ARG_BITS-1:0];
         job_data.omin    = omin_map;
      end
      job_data.divide = job_data.valid && (job_data.den_mag != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_ff <= SCREEN_HOME;
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            window_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_TRIM; i++) begin
            trim_ff[i] <= '0;
         end
      end else if (accept && is_event) begin
         screen_ff    <= screen_in;
         window_ff[0] <= window_ff[1];
         window_ff[1] <= window_ff[2];
         window_ff[2] <= req_data.event_byte;
         for (int i = 0; i < NUM_TRIM; i++) begin
            trim_ff[i] <= trim_in[i];
         end
      end
   end

endmodule

`default_nettype wire

[hdl/sstt_queue.sv]
`default_nettype none

module sstt_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  wire sstt_pkg::job_type push_data,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output sstt_pkg::job_type      pop_data
);
   import sstt_pkg::*;

   localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0]   PTR_LAST   = PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_FULL = COUNT_BITS'(QUEUE_DEPTH);

   job_type                entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   push, pop;

   assign push_ready = (count_ff != COUNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ((wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? ((rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[hdl/sstt_back.sv]
`default_nettype none

module sstt_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              job_valid,
   output logic                   job_ready,
   input  wire sstt_pkg::job_type job_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output sstt_pkg::rsp_type      rsp_data
);
   import sstt_pkg::*;

   localparam logic [ITER_BITS-1:0] ITER_LAST = ITER_BITS'(DIV_ITERS - 1);
   localparam logic signed [RES_BITS-1:0] RES_LO = RES_BITS'(CLAMP_LO);
   localparam logic signed [RES_BITS-1:0] RES_HI = RES_BITS'(CLAMP_HI);

   typedef enum logic [1:0] {ST_IDLE, ST_DIVIDE, ST_FINISH} state_type;

   state_type              state_ff;
   job_type                job_ff;
   logic [ARG_BITS-1:0]    rem_ff, rem_in;
   logic [QUO_BITS-1:0]    quo_ff, quo_in;
   logic [ITER_BITS-1:0]   iter_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff, rsp_in;

   logic [ARG_BITS:0]           trial_a, trial_b, den_ext;
   logic                        ge_a, ge_b;
   logic [ARG_BITS-1:0]         rem_a;
   logic [QUO_BITS-1:0]         quo_a;
   logic signed [RES_BITS-1:0]  quo_mag, quo_signed, sum;
   logic                        clamp_ch, out_free;

   assign job_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // two restoring steps per cycle
   always_comb begin
      den_ext = {1'b0, job_ff.den_mag};
      trial_a = {rem_ff, quo_ff[QUO_BITS-1]};
      ge_a    = (trial_a >= den_ext);
      rem_a   = ge_a ? ARG_BITS'(trial_a - den_ext) : trial_a[ARG_BITS-1:0];
      quo_a   = {quo_ff[QUO_BITS-2:0], ge_a};
      trial_b = {rem_a, quo_a[QUO_BITS-1]};
      ge_b    = (trial_b >= den_ext);
      rem_in  = ge_b ? ARG_BITS'(trial_b - den_ext) : trial_b[ARG_BITS-1:0];
      quo_in  = {quo_a[QUO_BITS-2:0], ge_b};
   end

   // sign fix, offset, trim and clamp
   always_comb begin
      clamp_ch   = job_ff.channel inside {[CH_THROTTLE:CH_PITCH]};
      quo_mag    = $signed(RES_BITS'(quo_ff));
      quo_signed = (job_ff.num_neg ^ job_ff.den_neg) ? -quo_mag : quo_mag;
      sum        = quo_signed + $signed(RES_BITS'(job_ff.omin)) +
                   (clamp_ch ? RES_BITS'(job_ff.trim) : '0);
      if (clamp_ch) begin
         if (sum > RES_HI) begin
            sum = RES_HI;
         end else if (sum < RES_LO) begin
            sum = RES_LO;
         end
      end
      rsp_in.out_channel  = job_ff.channel;
      rsp_in.value_valid  = job_ff.valid;
      rsp_in.screen_mode  = job_ff.screen;
      rsp_in.scaled_value = job_ff.valid ? sum[VALUE_BITS-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // the finish state reloads the response register itself
         if (rsp_valid_ff && rsp_ready && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  job_ff   <= job_data;
                  rem_ff   <= '0;
                  quo_ff   <= job_data.divide ? QUO_BITS'(job_data.num_mag) : '0;
                  iter_ff  <= '0;
                  state_ff <= job_data.divide ? ST_DIVIDE : ST_FINISH;
               end
            end
            ST_DIVIDE: begin
               rem_ff  <= rem_in;
               quo_ff  <= quo_in;
               iter_ff <= iter_ff + 1'b1;
               if (iter_ff == ITER_LAST) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_data_ff  <= rsp_in;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire
